// File: hdl/qte_pkg.sv
// ----------------------------------------------------------------------------
// qte_pkg
// shared widths, pipeline word types and the cordic arctangent table
// ----------------------------------------------------------------------------
package qte_pkg;

	localparam int COMPONENT_WIDTH = 16;
	localparam int ANGLE_WIDTH     = 16;
	localparam int CORDIC_STAGES   = 16;

	localparam int FRAC_BITS   = COMPONENT_WIDTH - 2;
	localparam int PROD_SHIFT  = (2 * FRAC_BITS > 28) ? (2 * FRAC_BITS - 28) : 0;
	localparam int SCALE_BITS  = 2 * FRAC_BITS - PROD_SHIFT;
	localparam int ANGLE_SHIFT = 32 - ANGLE_WIDTH;

	// product, term and cordic datapath widths
	localparam int PW  = 2 * COMPONENT_WIDTH;
	localparam int TW  = PW + 2;
	localparam int DW  = TW + 3;
	localparam int ZW  = 34;
	// clamped asin argument, radicand and square root cell count
	localparam int AW3 = SCALE_BITS + 2;
	localparam int RW  = 2 * SCALE_BITS + 1;
	localparam int SQ  = SCALE_BITS + 1;

	localparam logic signed [TW-1:0] ONE = TW'(1) <<< SCALE_BITS;
	localparam logic signed [ZW-1:0] QUARTER_TURN = ZW'(1) <<< 30;
	localparam logic signed [ZW-1:0] ROUND_HALF =
		(ANGLE_SHIFT > 0) ? (ZW'(1) <<< (ANGLE_SHIFT - 1)) : ZW'(0);
	localparam logic signed [ZW-1:0] ANGLE_QUARTER = ZW'(1) <<< (ANGLE_WIDTH - 2);

	typedef struct packed {
		logic [RW-1:0] v;
		logic [RW-1:0] r;
		logic [RW-1:0] b;
	} sq_t;

	typedef struct packed {
		logic signed [DW-1:0] x;
		logic signed [DW-1:0] y;
		logic signed [ZW-1:0] z;
		logic                 zero;
	} cd_t;

	function automatic logic signed [31:0] atan_tab(input logic [4:0] i);
		logic signed [31:0] a;
		unique case (i)
			5'd0:  a = 32'sd536870912;
			5'd1:  a = 32'sd316933406;
			5'd2:  a = 32'sd167458907;
			5'd3:  a = 32'sd85004756;
			5'd4:  a = 32'sd42667331;
			5'd5:  a = 32'sd21354465;
			5'd6:  a = 32'sd10679838;
			5'd7:  a = 32'sd5340245;
			5'd8:  a = 32'sd2670163;
			5'd9:  a = 32'sd1335087;
			5'd10: a = 32'sd667544;
			5'd11: a = 32'sd333772;
			5'd12: a = 32'sd166886;
			5'd13: a = 32'sd83443;
			5'd14: a = 32'sd41722;
			5'd15: a = 32'sd20861;
			5'd16: a = 32'sd10430;
			5'd17: a = 32'sd5215;
			5'd18: a = 32'sd2608;
			5'd19: a = 32'sd1304;
			5'd20: a = 32'sd652;
			5'd21: a = 32'sd326;
			5'd22: a = 32'sd163;
			5'd23: a = 32'sd81;
			5'd24: a = 32'sd41;
			5'd25: a = 32'sd20;
			5'd26: a = 32'sd10;
			5'd27: a = 32'sd5;
			5'd28: a = 32'sd3;
			5'd29: a = 32'sd1;
			5'd30: a = 32'sd1;
			5'd31: a = 32'sd0;
		endcase
		return a;
	endfunction

endpackage

// File: hdl/quaternion_to_euler_angles.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles
// pipeline from start to done: 4 product and term stages, one
// square root cell per root bit (29), pre-rotation, 16 cordic cells,
// rounding and the output register; one word accepted every cycle
// busy is never raised and done cannot be held off by the receiver
// reset clears only the valid pipe; data registers are not reset
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic signed [qte_pkg::COMPONENT_WIDTH-1:0] quat_x,
	input  logic signed [qte_pkg::COMPONENT_WIDTH-1:0] quat_y,
	input  logic signed [qte_pkg::COMPONENT_WIDTH-1:0] quat_z,
	input  logic signed [qte_pkg::COMPONENT_WIDTH-1:0] quat_w,
	output logic                                   done,
	output logic signed [qte_pkg::ANGLE_WIDTH-1:0] angle_about_x,
	output logic signed [qte_pkg::ANGLE_WIDTH-1:0] angle_about_y,
	output logic signed [qte_pkg::ANGLE_WIDTH-1:0] angle_about_z
);
	import qte_pkg::*;

	localparam int LAT = 4 + SQ + CORDIC_STAGES + 3;

	// terms carried alongside the square root row
	typedef struct packed {
		logic signed [TW-1:0]  t0;
		logic signed [TW-1:0]  t1;
		logic signed [AW3-1:0] t3;
		logic signed [TW-1:0]  t5;
		logic signed [TW-1:0]  t6;
	} terms_t;

	function automatic logic signed [PW-1:0] mul(
		input logic signed [COMPONENT_WIDTH-1:0] a,
		input logic signed [COMPONENT_WIDTH-1:0] b
	);
		logic signed [PW-1:0] p;
		p = PW'(a) * PW'(b);
		return p >>> PROD_SHIFT;
	endfunction

	logic [LAT-1:0] vld_q;

	logic signed [PW-1:0] wx_s1, yz_s1, xx_s1, yy_s1, wy_s1, zx_s1, wz_s1, xy_s1, zz_s1;
	terms_t               terms_s2, terms_s3, terms_s4;
	logic signed [TW-1:0] t3_full;
	logic signed [2*AW3-1:0] t3sq_s3;
	logic [RW-1:0]        rad_s4;
	logic signed [2*AW3-1:0] rad_full;

	terms_t dly_q [SQ];
	sq_t    sq_row [SQ+1];
	logic signed [DW-1:0] root;

	logic signed [ZW-1:0] ax, ay, az;

	// no back-pressure anywhere in the pipe
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], start};
		end
	end

	assign done = vld_q[LAT-1];

	// stage 1: the nine component products
	always_ff @(posedge clk) begin
		wx_s1 <= mul(quat_w, quat_x);
		yz_s1 <= mul(quat_y, quat_z);
		xx_s1 <= mul(quat_x, quat_x);
		yy_s1 <= mul(quat_y, quat_y);
		wy_s1 <= mul(quat_w, quat_y);
		zx_s1 <= mul(quat_z, quat_x);
		wz_s1 <= mul(quat_w, quat_z);
		xy_s1 <= mul(quat_x, quat_y);
		zz_s1 <= mul(quat_z, quat_z);
	end

	// stage 2: atan2 operands and the saturated asin argument
	assign t3_full = (TW'(wy_s1) - TW'(zx_s1)) <<< 1;

	always_ff @(posedge clk) begin
		terms_s2.t0 <= (TW'(wx_s1) + TW'(yz_s1)) <<< 1;
		terms_s2.t1 <= ONE - ((TW'(xx_s1) + TW'(yy_s1)) <<< 1);
		terms_s2.t5 <= (TW'(wz_s1) + TW'(xy_s1)) <<< 1;
		terms_s2.t6 <= ONE - ((TW'(yy_s1) + TW'(zz_s1)) <<< 1);
		priority if (t3_full > ONE) begin
			terms_s2.t3 <= AW3'(ONE);
		end else if (t3_full < -ONE) begin
			terms_s2.t3 <= AW3'(-ONE);
		end else begin
			terms_s2.t3 <= AW3'(t3_full);
		end
	end

	// stage 3: square of the asin argument
	always_ff @(posedge clk) begin
		terms_s3 <= terms_s2;
		t3sq_s3  <= (2*AW3)'(terms_s2.t3) * (2*AW3)'(terms_s2.t3);
	end

	// stage 4: radicand one squared minus t3 squared
	assign rad_full = ((2*AW3)'(1) <<< (2 * SCALE_BITS)) - t3sq_s3;

	always_ff @(posedge clk) begin
		terms_s4 <= terms_s3;
		rad_s4   <= RW'(rad_full);
	end

	// square root row, one root bit per cell
	assign sq_row[0].v = rad_s4;
	assign sq_row[0].r = '0;
	assign sq_row[0].b = RW'(1) << (2 * SCALE_BITS);

	for (genvar k = 0; k < SQ; k++) begin : g_sqrt
		qte_sqrt_cell u_sqrt (
			.clk  (clk),
			.din  (sq_row[k]),
			.dout (sq_row[k+1])
		);
	end

	// terms wait beside the root row
	always_ff @(posedge clk) begin
		dly_q[0] <= terms_s4;
		for (int k = 1; k < SQ; k++) begin
			dly_q[k] <= dly_q[k-1];
		end
	end

	assign root = DW'($signed({1'b0, sq_row[SQ].r[SQ-1:0]}));

	qte_cordic u_cordic_x (
		.clk   (clk),
		.im    (DW'(dly_q[SQ-1].t0)),
		.re    (DW'(dly_q[SQ-1].t1)),
		.angle (ax)
	);

	qte_cordic u_cordic_y (
		.clk   (clk),
		.im    (DW'(dly_q[SQ-1].t3)),
		.re    (root),
		.angle (ay)
	);

	qte_cordic u_cordic_z (
		.clk   (clk),
		.im    (DW'(dly_q[SQ-1].t5)),
		.re    (DW'(dly_q[SQ-1].t6)),
		.angle (az)
	);

	// output word: wrap to angle width, asin result held within a quarter turn
	always_ff @(posedge clk) begin
		angle_about_x <= ANGLE_WIDTH'(ax);
		angle_about_z <= ANGLE_WIDTH'(az);
		priority if (ay > ANGLE_QUARTER) begin
			angle_about_y <= ANGLE_WIDTH'(ANGLE_QUARTER);
		end else if (ay < -ANGLE_QUARTER) begin
			angle_about_y <= ANGLE_WIDTH'(-ANGLE_QUARTER);
		end else begin
			angle_about_y <= ANGLE_WIDTH'(ay);
		end
	end

endmodule

// File: hdl/qte_sqrt_cell.sv
// ----------------------------------------------------------------------------
// qte_sqrt_cell
// one registered step of the bit-pair integer square root
// ----------------------------------------------------------------------------
module qte_sqrt_cell (
	input  logic         clk,
	input  qte_pkg::sq_t din,
	output qte_pkg::sq_t dout
);
	import qte_pkg::*;

	logic [RW-1:0] trial;
	sq_t           nxt;

	always_comb begin
		trial = din.r + din.b;
		if (din.v >= trial) begin
			nxt.v = din.v - trial;
			nxt.r = (din.r >> 1) + din.b;
		end else begin
			nxt.v = din.v;
			nxt.r = din.r >> 1;
		end
		nxt.b = din.b >> 2;
	end

	always_ff @(posedge clk) begin
		dout <= nxt;
	end

endmodule

// File: hdl/qte_cordic_cell.sv
// ----------------------------------------------------------------------------
// qte_cordic_cell
// one registered vectoring micro-rotation
// ----------------------------------------------------------------------------
module qte_cordic_cell (
	input  logic         clk,
	input  logic [4:0]   idx,
	input  qte_pkg::cd_t din,
	output qte_pkg::cd_t dout
);
	import qte_pkg::*;

	logic signed [DW-1:0] dx;
	logic signed [DW-1:0] dy;
	logic signed [ZW-1:0] da;
	cd_t                  nxt;

	always_comb begin
		dx = din.y >>> idx;
		dy = din.x >>> idx;
		da = ZW'(atan_tab(idx));
		nxt.zero = din.zero;
		if (din.y > 0) begin
			nxt.x = din.x + dx;
			nxt.y = din.y - dy;
			nxt.z = din.z + da;
		end else begin
			nxt.x = din.x - dx;
			nxt.y = din.y + dy;
			nxt.z = din.z - da;
		end
	end

	always_ff @(posedge clk) begin
		dout <= nxt;
	end

endmodule

// File: hdl/qte_cordic.sv
// ----------------------------------------------------------------------------
// qte_cordic
// atan2 pipeline: half-plane pre-rotation, row of cells, rounding
// ----------------------------------------------------------------------------
module qte_cordic (
	input  logic                          clk,
	input  logic signed [qte_pkg::DW-1:0] im,
	input  logic signed [qte_pkg::DW-1:0] re,
	output logic signed [qte_pkg::ZW-1:0] angle
);
	import qte_pkg::*;

	cd_t pre;
	cd_t row [CORDIC_STAGES+1];
	logic signed [ZW-1:0] rnd;

	// fold the left half plane by a quarter turn
	always_comb begin
		pre.zero = (im == '0) && (re == '0);
		if (re < 0) begin
			if (im >= 0) begin
				pre.x = im;
				pre.y = -re;
				pre.z = QUARTER_TURN;
			end else begin
				pre.x = -im;
				pre.y = re;
				pre.z = -QUARTER_TURN;
			end
		end else begin
			pre.x = re;
			pre.y = im;
			pre.z = '0;
		end
	end

	always_ff @(posedge clk) begin
		row[0] <= pre;
	end

	for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
		qte_cordic_cell u_cell (
			.clk  (clk),
			.idx  (5'(k)),
			.din  (row[k]),
			.dout (row[k+1])
		);
	end

	assign rnd = (row[CORDIC_STAGES].z + ROUND_HALF) >>> ANGLE_SHIFT;

	always_ff @(posedge clk) begin
		angle <= row[CORDIC_STAGES].zero ? '0 : rnd;
	end

endmodule
